[rtl/ppp_pkg.sv]
// Shared types and constants for the pinhole point projector.
// No dependencies; every other rtl file imports this package.
package ppp_pkg;

  localparam int ZW    = 32;   // depth width, 2^-24 m units
  localparam int FW    = 24;   // Q16.8 focal length / center width
  localparam int CW    = 53;   // signed camera coordinate width
  localparam int HW    = 26;   // half of the 52-bit magnitude
  localparam int PRW   = 50;   // partial product width
  localparam int NW    = 76;   // numerator magnitude * focal
  localparam int QBITS = 26;   // quotient bits kept, larger saturates
  localparam int IW    = 13;   // image dimension width
  localparam int PW    = 14;   // pixel output width

  localparam logic signed [CW-1:0] NEAR_DEPTH = 53'sd16777216;
  localparam logic signed [CW-1:0] FAR_DEPTH  = 53'sd3355443200;

  typedef enum logic [2:0] {
    REG_ROT0,
    REG_ROT1,
    REG_ROT2,
    REG_TXY,
    REG_TZ,
    REG_FOCAL,
    REG_CENTER,
    REG_SIZE
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][53:0]    rot;     // row i, entry j at bits 18j+17:18j
    logic [2:0][ZW-1:0]  trans;   // x, y, z
    logic [1:0][FW-1:0]  focal;   // fx, fy
    logic [1:0][FW-1:0]  center;  // cx, cy
    logic [1:0][IW-1:0]  size;    // width, height
  } cfg_t;

  typedef struct packed {
    logic [NW-1:0] num;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t [1:0]   lane;
    logic [ZW-1:0] z;
    logic          depth_ok;
    logic          flip;
  } proj_t;

  typedef struct packed {
    logic [1:0][QBITS-1:0] quot;
    logic [1:0]            neg;
    logic                  depth_ok;
    logic                  flip;
  } quot_t;

  typedef struct packed {
    logic [PW-1:0] col;
    logic [PW-1:0] row;
    logic          vis;
  } res_t;

endpackage

[rtl/pinhole_point_projector.sv]
// Pinhole point projector top level: register file, stream ports, pipeline.
// Depends on ppp_pkg, ppp_transform, ppp_divider and ppp_pixel.
//
// Usage: write the eight 64-bit registers over the APB port (register i at
// byte address 8*i) while no word is in flight, then stream map points in on
// the s_ side. Each accepted word gives exactly one word on the m_ side:
// projected column and row with the visible flag in m_tuser, or -1,-1 with
// visible low when the depth is outside 1 m..200 m or the pixel is outside
// the image.
// Pipeline: 34 register stages, most of them in the divider (an input
// register plus 26 stages of one quotient bit each), with four transform
// stages and three pixel stages.
// Throughput: one word per cycle while s_tready is high.
// Reset clears the configuration registers to zero and empties the pipeline.
// When the receiver stalls, the output register holds its word and one more
// word parks in a skid register; only then does s_tready drop and the whole
// pipeline hold.
module pinhole_point_projector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // point_x, point_y, point_z
  input  logic        s_tuser,   // flip_vertical
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_col, pixel_row, zero fill
  output logic        m_tuser,   // visible
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ppp_pkg::*;

  cfg_t     cfg;
  reg_idx_t idx;
  logic     ce;
  logic     tr_valid, dv_valid;
  proj_t    tr_out;
  quot_t    dv_out;
  res_t     res;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_ROT0:   cfg.rot[0]   <= pwdata[53:0];
        REG_ROT1:   cfg.rot[1]   <= pwdata[53:0];
        REG_ROT2:   cfg.rot[2]   <= pwdata[53:0];
        REG_TXY: begin
          cfg.trans[0] <= pwdata[31:0];
          cfg.trans[1] <= pwdata[63:32];
        end
        REG_TZ:     cfg.trans[2] <= pwdata[31:0];
        REG_FOCAL:  cfg.focal    <= pwdata[47:0];
        REG_CENTER: cfg.center   <= pwdata[47:0];
        REG_SIZE:   cfg.size     <= pwdata[25:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROT0:   prdata = 64'(cfg.rot[0]);
      REG_ROT1:   prdata = 64'(cfg.rot[1]);
      REG_ROT2:   prdata = 64'(cfg.rot[2]);
      REG_TXY:    prdata = {cfg.trans[1], cfg.trans[0]};
      REG_TZ:     prdata = 64'(cfg.trans[2]);
      REG_FOCAL:  prdata = 64'(cfg.focal);
      REG_CENTER: prdata = 64'(cfg.center);
      REG_SIZE:   prdata = 64'(cfg.size);
    endcase
  end

  assign s_tready = ce;

  ppp_transform u_transform (
    .clk           (clk),
    .rst           (rst),
    .ce            (ce),
    .cfg           (cfg),
    .in_valid      (s_tvalid),
    .point_x       ($signed(s_tdata[31:0])),
    .point_y       ($signed(s_tdata[63:32])),
    .point_z       ($signed(s_tdata[95:64])),
    .flip_vertical (s_tuser),
    .out_valid     (tr_valid),
    .out           (tr_out)
  );

  ppp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (tr_valid),
    .in        (tr_out),
    .out_valid (dv_valid),
    .out       (dv_out)
  );

  ppp_pixel u_pixel (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (dv_valid),
    .in        (dv_out),
    .ce        (ce),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out       (res)
  );

  assign m_tdata = {4'b0, res.row, res.col};
  assign m_tuser = res.vis;

endmodule

[rtl/ppp_transform.sv]
// Rigid transform and focal scaling: four register stages.
// Depends on ppp_pkg.
module ppp_transform (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  ppp_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  input  logic                flip_vertical,
  output logic                out_valid,
  output ppp_pkg::proj_t      out
);
  import ppp_pkg::*;

  logic [3:0]               v;
  logic signed [31:0]       pt   [3];
  logic signed [PRW-1:0]    prod [3][3];
  logic                     flip1;
  logic signed [CW-1:0]     cam  [3];
  logic                     flip2;
  logic [CW-2:0]            mag  [2];
  logic [1:0][PRW-1:0]      plo;
  logic [1:0][PRW-1:0]      phi;
  logic [1:0]               neg3;
  logic [ZW-1:0]            z3;
  logic                     dok3;
  logic                     flip3;
  proj_t                    q4;

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l] = cam[l][CW-1] ? (CW-1)'(-cam[l]) : (CW-1)'(cam[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PRW'($signed(cfg.rot[i][18*j +: 18])) * PRW'(pt[j]);
        end
      end
      flip1 <= flip_vertical;

      for (int i = 0; i < 3; i++) begin
        cam[i] <= CW'(prod[i][0]) + CW'(prod[i][1]) + CW'(prod[i][2])
                + (CW'($signed(cfg.trans[i])) <<< 16);
      end
      flip2 <= flip1;

      for (int l = 0; l < 2; l++) begin
        plo[l]  <= PRW'(mag[l][HW-1:0]) * PRW'(cfg.focal[l]);
        phi[l]  <= PRW'(mag[l][2*HW-1:HW]) * PRW'(cfg.focal[l]);
        neg3[l] <= cam[l][CW-1];
      end
      z3    <= cam[2][ZW-1:0];
      dok3  <= (cam[2] >= NEAR_DEPTH) && (cam[2] <= FAR_DEPTH);
      flip3 <= flip2;

      for (int l = 0; l < 2; l++) begin
        q4.lane[l].num <= (NW'(phi[l]) << HW) + NW'(plo[l]);
        q4.lane[l].neg <= neg3[l];
      end
      q4.z        <= z3;
      q4.depth_ok <= dok3;
      q4.flip     <= flip3;
    end
  end

  assign out_valid = v[3];
  assign out       = q4;

endmodule

[rtl/ppp_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// Depends on ppp_pkg.
module ppp_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           ce,
  input  logic           in_valid,
  input  ppp_pkg::proj_t in,
  output logic           out_valid,
  output ppp_pkg::quot_t out
);
  import ppp_pkg::*;

  localparam int NS = QBITS + 1;

  typedef struct packed {
    logic [1:0][ZW-1:0]    rem;
    logic [1:0][QBITS-1:0] low;
    logic [1:0][QBITS-1:0] quot;
    logic [1:0]            sat;
    logic [1:0]            neg;
    logic [ZW-1:0]         z;
    logic                  depth_ok;
    logic                  flip;
  } div_stage_t;

  logic [NS-1:0] v;
  div_stage_t    st  [NS];
  div_stage_t    nxt [NS];

  always_comb begin
    logic [ZW:0] rsh;
    logic        ge;
    rsh = '0;
    ge  = 1'b0;
    for (int l = 0; l < 2; l++) begin
      nxt[0].rem[l]  = in.lane[l].num[HW+ZW-1:HW];
      nxt[0].low[l]  = in.lane[l].num[QBITS-1:0];
      nxt[0].quot[l] = '0;
      nxt[0].sat[l]  = in.lane[l].num[NW-1:HW] >= (NW-HW)'(in.z);
      nxt[0].neg[l]  = in.lane[l].neg;
    end
    nxt[0].z        = in.z;
    nxt[0].depth_ok = in.depth_ok;
    nxt[0].flip     = in.flip;
    for (int k = 1; k < NS; k++) begin
      nxt[k] = st[k-1];
      for (int l = 0; l < 2; l++) begin
        rsh = {st[k-1].rem[l], st[k-1].low[l][QBITS-1]};
        ge  = rsh >= {1'b0, st[k-1].z};
        nxt[k].rem[l]  = ge ? ZW'(rsh - {1'b0, st[k-1].z}) : rsh[ZW-1:0];
        nxt[k].low[l]  = {st[k-1].low[l][QBITS-2:0], 1'b0};
        nxt[k].quot[l] = {st[k-1].quot[l][QBITS-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NS; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      out.quot[l] = st[NS-1].sat[l] ? '1 : st[NS-1].quot[l];
    end
    out.neg      = st[NS-1].neg;
    out.depth_ok = st[NS-1].depth_ok;
    out.flip     = st[NS-1].flip;
  end

  assign out_valid = v[NS-1];

endmodule

[rtl/ppp_pixel.sv]
// Principal point offset, bounds check, flip, output register and skid word.
// Depends on ppp_pkg; drives the pipeline advance for all stages.
module ppp_pixel (
  input  logic           clk,
  input  logic           rst,
  input  ppp_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  ppp_pkg::quot_t in,
  output logic           ce,
  output logic           out_valid,
  input  logic           out_ready,
  output ppp_pkg::res_t  out
);
  import ppp_pkg::*;

  logic                 v1, v2;
  logic signed [27:0]   s [2];
  logic                 dok1, flip1;
  logic [1:0][IW-1:0]   pix2;
  logic                 vis2, flip2;
  logic [18:0]          mag [2];
  logic [1:0]           inr;
  logic [IW-1:0]        row_f;
  res_t                 res;
  logic                 xfer;
  logic                 ov, kv;
  res_t                 od, kd;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l] = s[l][27] ? 19'd0 : s[l][26:8];
      inr[l] = (s[l] >= -28'sd255) && (mag[l] <= 19'(cfg.size[l]));
    end
  end

  always_comb begin
    row_f   = flip2 ? cfg.size[1] - pix2[1] : pix2[1];
    res.col = vis2 ? {1'b0, pix2[0]} : '1;
    res.row = vis2 ? {1'b0, row_f} : '1;
    res.vis = vis2;
  end

  assign ce   = !kv;
  assign xfer = v2 && ce;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < 2; l++) begin
        s[l] <= (in.neg[l] ? -28'(in.quot[l]) : 28'(in.quot[l])) + 28'(cfg.center[l]);
      end
      dok1  <= in.depth_ok;
      flip1 <= in.flip;
      for (int l = 0; l < 2; l++) begin
        pix2[l] <= mag[l][IW-1:0];
      end
      vis2  <= dok1 && inr[0] && inr[1];
      flip2 <= flip1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
      kv <= 1'b0;
    end else begin
      if (ce) begin
        v1 <= in_valid;
        v2 <= v1;
      end
      if (!ov || out_ready) begin
        if (kv) begin
          ov <= 1'b1;
          kv <= 1'b0;
        end else begin
          ov <= xfer;
        end
      end else if (xfer) begin
        kv <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || out_ready) begin
      od <= kv ? kd : res;
    end else if (xfer) begin
      kd <= res;
    end
  end

  assign out_valid = ov;
  assign out       = od;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) kv |-> ov)
    else $error("skid word held with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_ready && xfer) |=> kv)
    else $error("word arriving at a stalled output was not parked");

  a_hidden_word: assert property (@(posedge clk) disable iff (rst)
    (ov && !od.vis) |-> (od.col == '1 && od.row == '1))
    else $error("hidden point without -1 coordinates");

endmodule

[test/tb_top.sv]
// Testbench for pinhole_point_projector: APB register setup, streamed map points,
// and an in-bench projection model that checks every output word. Depends on ppp_pkg.
`timescale 1ns / 1ps

module tb_top;
  import ppp_pkg::*;

  localparam int LATENCY     = 34;
  localparam int STALL_LIMIT = 3000;
  localparam longint unsigned SAT_Q = 64'd1 << 40;

  typedef struct {
    logic [13:0] col;
    logic [13:0] row;
    logic        vis;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // point_x, point_y, point_z
  logic        s_tuser = 1'b0; // flip_vertical
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // pixel_col, pixel_row, zero fill
  logic        m_tuser;        // visible
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  logic [63:0] cam_regs [8];
  pixel_t      pending_pixels [$];
  int          errors = 0;
  int          points_sent = 0;
  int          words_seen = 0;
  int          visible_seen = 0;
  int          idle_cycles = 0;
  int          rx_hold = 0;
  bit          rx_free = 1'b0;
  bit          tx_free = 1'b0;

  pinhole_point_projector u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint pixel_coord(longint num, longint unsigned f,
                                         longint unsigned c, longint unsigned z);
    longint unsigned a, qa, ra, q;
    longint s;
    a  = (num < 0) ? longint'(-num) : num;
    qa = a / z;
    ra = a % z;
    q  = qa * f + (ra * f) / z;
    if (q > SAT_Q) q = SAT_Q;
    s = ((num < 0) ? -longint'(q) : longint'(q)) + longint'(c);
    if (s >= 0) return s >>> 8;
    return -((-s) >>> 8);
  endfunction

  function automatic longint cam_axis(logic [63:0] rot, longint px, longint py,
                                      longint pz, longint t);
    longint e0, e1, e2;
    e0 = longint'($signed(rot[17:0]));
    e1 = longint'($signed(rot[35:18]));
    e2 = longint'($signed(rot[53:36]));
    return e0 * px + e1 * py + e2 * pz + t * 65536;
  endfunction

  function automatic pixel_t project_point(logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z, logic flip);
    pixel_t r;
    longint px, py, pz, cx3, cy3, cz3, col, row, w, h;
    px  = longint'($signed(x));
    py  = longint'($signed(y));
    pz  = longint'($signed(z));
    cx3 = cam_axis(cam_regs[REG_ROT0], px, py, pz, longint'($signed(cam_regs[REG_TXY][31:0])));
    cy3 = cam_axis(cam_regs[REG_ROT1], px, py, pz, longint'($signed(cam_regs[REG_TXY][63:32])));
    cz3 = cam_axis(cam_regs[REG_ROT2], px, py, pz, longint'($signed(cam_regs[REG_TZ][31:0])));
    w   = cam_regs[REG_SIZE][12:0];
    h   = cam_regs[REG_SIZE][25:13];
    r.col = 14'h3FFF;
    r.row = 14'h3FFF;
    r.vis = 1'b0;
    if (cz3 < (64'sd1 << 24) || cz3 > (64'sd200 << 24)) return r;
    col = pixel_coord(cx3, cam_regs[REG_FOCAL][23:0], cam_regs[REG_CENTER][23:0], cz3);
    row = pixel_coord(cy3, cam_regs[REG_FOCAL][47:24], cam_regs[REG_CENTER][47:24], cz3);
    if (col < 0 || col > w || row < 0 || row > h) return r;
    if (flip) row = h - row;
    r.col = col[13:0];
    r.row = row[13:0];
    r.vis = 1'b1;
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [63:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROT0, REG_ROT1, REG_ROT2: cam_regs[idx] = v & 64'h003F_FFFF_FFFF_FFFF;
      REG_TXY:                      cam_regs[idx] = v;
      REG_TZ:                       cam_regs[idx] = v & 64'hFFFF_FFFF;
      REG_FOCAL, REG_CENTER:        cam_regs[idx] = v & 64'h0000_FFFF_FFFF_FFFF;
      default:                      cam_regs[idx] = v & 64'h03FF_FFFF;
    endcase
  endtask

  task automatic drain;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic set_camera(logic [17:0] r00, logic [17:0] r11, logic [17:0] r22,
                            logic [63:0] txy, logic [31:0] tz, logic [23:0] f,
                            logic [23:0] c_x, logic [23:0] c_y, logic [12:0] w,
                            logic [12:0] h);
    drain();
    write_reg(REG_ROT0, {36'd0, r00});
    write_reg(REG_ROT1, {18'd0, r11, 18'd0});
    write_reg(REG_ROT2, {r22, 36'd0});
    write_reg(REG_TXY, txy);
    write_reg(REG_TZ, {32'd0, tz});
    write_reg(REG_FOCAL, {16'd0, f, f});
    write_reg(REG_CENTER, {16'd0, c_y, c_x});
    write_reg(REG_SIZE, {38'd0, h, w});
  endtask

  function automatic int pick_gap();
    int r;
    if (tx_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic flip);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tuser  <= flip;
    do @(posedge clk); while (!s_tready);
    pending_pixels.insert(pending_pixels.size(), project_point(x, y, z, flip));
    points_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic stop_sending;
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Mostly points in front of the camera within the field of view, some noise.
  task automatic send_scene_point(int span_num, int span_den);
    logic [31:0] x, y, z;
    int zz, sp;
    if ($urandom_range(0, 9) < 2) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end else begin
      zz = $urandom_range(200, 52000);
      sp = zz * span_num / span_den;
      z  = zz;
      x  = int'($urandom_range(0, 2 * sp)) - sp;
      y  = int'($urandom_range(0, 2 * sp)) - sp;
    end
    send_point(x, y, z, 1'($urandom_range(0, 1)));
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else if (rx_free) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 149) == 0) begin
      m_tready <= 1'b0;
      rx_hold  <= $urandom_range(10, 40);
    end else begin
      m_tready <= ($urandom_range(0, 9) > 2);
    end
  end

  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst && m_tvalid && m_tready) begin
      words_seen++;
      if (m_tuser) visible_seen++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected word col=%h row=%h vis=%b", $time,
                 m_tdata[13:0], m_tdata[27:14], m_tuser);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (m_tdata[13:0] !== exp_px.col) begin
          $display("%0t: pixel_col expected %h actual %h", $time, exp_px.col, m_tdata[13:0]);
          errors++;
        end
        if (m_tdata[27:14] !== exp_px.row) begin
          $display("%0t: pixel_row expected %h actual %h", $time, exp_px.row, m_tdata[27:14]);
          errors++;
        end
        if (m_tdata[31:28] !== 4'd0) begin
          $display("%0t: fill bits expected 0 actual %h", $time, m_tdata[31:28]);
          errors++;
        end
        if (m_tuser !== exp_px.vis) begin
          $display("%0t: visible expected %b actual %b", $time, exp_px.vis, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d words outstanding", $time, pending_pixels.size());
      $display("pinhole_point_projector verification failed");
      $finish;
    end
  end

  // 640x480 camera looking along +z, 320 px focal length.
  task automatic test_directed;
    set_camera(18'h10000, 18'h10000, 18'h10000, 64'd0, 32'd0, 24'd81920,
               24'd81920, 24'd61440, 13'd640, 13'd480);
    send_point(32'd0, 32'd0, 32'd2560, 1'b0);
    send_point(32'd0, 32'd0, 32'd2560, 1'b1);
    send_point(32'd0, 32'd0, 32'd256, 1'b0);         // near limit
    send_point(32'd0, 32'd0, 32'd255, 1'b0);
    send_point(32'd0, 32'd0, 32'd51200, 1'b1);       // far limit
    send_point(32'd0, 32'd0, 32'd51201, 1'b0);
    send_point(32'd0, 32'd0, 32'd0, 1'b1);           // zero depth
    send_point(32'd5, 32'd5, 32'hFFFF_F000, 1'b0);   // behind camera
    send_point(32'd1000, 32'd0, 32'd1000, 1'b0);     // right edge, inclusive
    send_point(32'd1001, 32'd0, 32'd1000, 1'b0);
    send_point(-32'sd1000, 32'd0, 32'd1000, 1'b1);   // left edge
    send_point(-32'sd1001, 32'd0, 32'd1000, 1'b0);
    send_point(32'd0, 32'd750, 32'd1000, 1'b1);      // bottom edge
    send_point(32'd0, 32'd751, 32'd1000, 1'b1);
    send_point(32'd0, -32'sd750, 32'd1000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'd0, 32'd256, 1'b0); // saturated quotient
    send_point(32'h8000_0000, 32'd0, 32'd256, 1'b0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd300, 1'b1);
    stop_sending();
  endtask

  task automatic test_identity_scene;
    for (int i = 0; i < 650; i++) begin
      if (i == 300) rx_free = 1'b1;
      if (i == 400) tx_free = 1'b1;
      if (i == 500) begin
        rx_free = 1'b0;
        tx_free = 1'b0;
      end
      send_scene_point(5, 4);
    end
    stop_sending();
  endtask

  // Axes flipped by negative rotation, offset translation, unequal center.
  task automatic test_rotated_scene;
    set_camera(18'h30000, 18'h38000, 18'h10000, {32'hFFFF_FC00, 32'd1280}, 32'hFFFF_FF00,
               24'd102400, 24'd100000, 24'd50000, 13'd800, 13'd600);
    for (int i = 0; i < 500; i++) send_scene_point(2, 3);
    stop_sending();
  endtask

  task automatic test_backpressure;
    drain();
    rx_hold  = 400;
    tx_free  = 1'b1;
    for (int i = 0; i < 120; i++) send_scene_point(5, 4);
    tx_free  = 1'b0;
    stop_sending();
  endtask

  // Every register at its top value, bits beyond each width included, then extreme rotation and translation.
  task automatic test_extreme_config;
    drain();
    for (int k = 0; k < 8; k++) write_reg(reg_idx_t'(k), 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 120; i++) send_scene_point(1, 1);
    stop_sending();
    drain();
    write_reg(REG_ROT0, {36'd0, 18'h20000});
    write_reg(REG_ROT1, {18'd0, 18'h1FFFF, 18'd0});
    write_reg(REG_ROT2, {18'h1FFFF, 36'd0});
    write_reg(REG_TXY, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(REG_TZ, 64'h0000_0000_8000_0000);
    for (int i = 0; i < 80; i++) send_scene_point(1, 1);
    stop_sending();
  endtask

  task automatic test_zero_image;
    set_camera(18'h10000, 18'h10000, 18'h10000, 64'd0, 32'd0, 24'd0,
               24'd255, 24'd0, 13'd0, 13'd0);
    for (int i = 0; i < 100; i++) send_scene_point(1, 4);
    stop_sending();
    set_camera(18'h10000, 18'h10000, 18'h10000, 64'd0, 32'd0, 24'd256,
               24'd0, 24'd0, 13'd0, 13'd0);
    for (int i = 0; i < 100; i++) send_scene_point(1, 4);
    stop_sending();
  endtask

  initial begin
    for (int k = 0; k < 8; k++) cam_regs[k] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_identity_scene();
    test_rotated_scene();
    test_backpressure();
    test_extreme_config();
    test_zero_image();
    drain();
    $display("Sent %0d points over six camera setups, %0d words checked, %0d visible.",
             points_sent, words_seen, visible_seen);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("pinhole_point_projector verification clean");
    end else begin
      $display("pinhole_point_projector verification failed");
    end
    $finish;
  end

endmodule
